// File: design/bcc_pkg.sv
// ----------------------------------------------------------------------------
// bcc_pkg
// Shared types, constants and helpers for the button click classifier.
// ----------------------------------------------------------------------------
package bcc_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int REG_WIDTH   = 16;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [REG_WIDTH-1:0]   reg_val_t;
  typedef logic [1:0]             event_t;
  typedef logic                   reg_index_t;

  localparam event_t EV_NONE   = 2'd0;
  localparam event_t EV_SINGLE = 2'd1;
  localparam event_t EV_DOUBLE = 2'd2;
  localparam event_t EV_LONG   = 2'd3;

  localparam reg_index_t REG_LONG_PRESS   = 1'b0;
  localparam reg_index_t REG_CLICK_WINDOW = 1'b1;

  localparam reg_val_t LONG_PRESS_RESET   = 16'd100;
  localparam reg_val_t CLICK_WINDOW_RESET = 16'd20;

  typedef enum logic [4:0] {
    PH_IDLE  = 5'b00001,
    PH_PUSH1 = 5'b00010,
    PH_REL1  = 5'b00100,
    PH_PUSH2 = 5'b01000,
    PH_LONG  = 5'b10000
  } phase_t;

  typedef struct packed {
    reg_val_t long_press_ticks;
    reg_val_t click_window_ticks;
  } cfg_t;

  // register value masked or extended to the counter width
  function automatic count_t fit_count(input reg_val_t v);
    logic [COUNT_WIDTH+REG_WIDTH-1:0] tmp;
    tmp = {{COUNT_WIDTH{1'b0}}, v};
    return tmp[COUNT_WIDTH-1:0];
  endfunction

endpackage

// File: design/button_click_classifier.sv
// ----------------------------------------------------------------------------
// button_click_classifier
// Classifies sampled button levels into single, double and long clicks.
// ----------------------------------------------------------------------------
// result: the result beat is registered and appears in the cycle after its input beat is accepted
// throughput: one beat per cycle while the output is not stalled; the state updates on each accepted beat
// reset: synchronous; phase idle, counters zero, registers 100 and 20,
// output register empty
module button_click_classifier import bcc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       pressed,
  output logic       out_valid,
  input  logic       out_stall,
  output event_t     event_res,
  input  logic       wr_en,
  input  reg_index_t wr_index,
  input  reg_val_t   wr_data
);

  cfg_t   cfg;
  event_t ev;
  logic   in_accept;
  logic   out_valid_next;

  assign in_stall       = out_valid & out_stall;
  assign in_accept      = in_valid & ~in_stall;
  assign out_valid_next = in_accept | (out_valid & out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.long_press_ticks   <= LONG_PRESS_RESET;
      cfg.click_window_ticks <= CLICK_WINDOW_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_LONG_PRESS:   cfg.long_press_ticks   <= wr_data;
        REG_CLICK_WINDOW: cfg.click_window_ticks <= wr_data;
        default: ;
      endcase
    end
  end

  bcc_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (in_accept),
    .pressed (pressed),
    .cfg     (cfg),
    .ev      (ev)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      event_res <= ev;
    end
  end

endmodule

// File: design/bcc_core.sv
// ----------------------------------------------------------------------------
// bcc_core
// Press pattern state machine with hold and click window counters.
// ----------------------------------------------------------------------------
module bcc_core import bcc_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   step,
  input  logic   pressed,
  input  cfg_t   cfg,
  output event_t ev
);

  phase_t phase, phase_next;
  count_t hold_counter, hold_counter_next;
  count_t window_counter, window_counter_next;
  count_t hold_dec, window_dec;

  assign hold_dec   = count_t'(hold_counter - count_t'(1));
  assign window_dec = count_t'(window_counter - count_t'(1));

  always_comb begin
    phase_next          = phase;
    hold_counter_next   = hold_counter;
    window_counter_next = window_counter;
    ev                  = EV_NONE;
    case (phase)
      PH_PUSH1: begin
        hold_counter_next = hold_dec;
        if (hold_dec == '0) begin
          ev         = EV_LONG;
          phase_next = PH_LONG;
        end else if (!pressed) begin
          window_counter_next = fit_count(cfg.click_window_ticks);
          phase_next          = PH_REL1;
        end
      end
      PH_REL1: begin
        window_counter_next = window_dec;
        if (window_dec == '0) begin
          ev         = EV_SINGLE;
          phase_next = PH_IDLE;
        end else if (pressed) begin
          phase_next = PH_PUSH2;
        end
      end
      PH_PUSH2: begin
        if (!pressed) begin
          ev         = EV_DOUBLE;
          phase_next = PH_IDLE;
        end
      end
      PH_LONG: begin
        if (!pressed) begin
          phase_next = PH_IDLE;
        end
      end
      default: begin
        if (pressed) begin
          hold_counter_next = fit_count(cfg.long_press_ticks);
          phase_next        = PH_PUSH1;
        end else begin
          phase_next = PH_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      hold_counter   <= '0;
      window_counter <= '0;
    end else if (step) begin
      phase          <= phase_next;
      hold_counter   <= hold_counter_next;
      window_counter <= window_counter_next;
    end
  end

`ifndef SYNTHESIS
  a_long_enters_long: assert property (@(posedge clk) disable iff (rst)
    step && ev == EV_LONG |=> phase == PH_LONG)
    else $error("long click without long press phase");

  a_double_to_idle: assert property (@(posedge clk) disable iff (rst)
    step && phase == PH_PUSH2 && !pressed |=> phase == PH_IDLE)
    else $error("double click release did not return to idle");

  a_hold_load: assert property (@(posedge clk) disable iff (rst)
    step && phase == PH_IDLE && pressed
    |=> phase == PH_PUSH1 && hold_counter == $past(fit_count(cfg.long_press_ticks)))
    else $error("hold counter not loaded on press");

  a_single_from_rel1: assert property (@(posedge clk) disable iff (rst)
    step && ev == EV_SINGLE |-> phase == PH_REL1 && window_counter == count_t'(1))
    else $error("single click outside expiring window");
`endif

endmodule
